// File: rtl/pbl_pkg.sv
// Shared types, codes and sizes for the positional byte list.
package pbl_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_INSERT     = 3'd4;
  localparam logic [2:0] KIND_DELETE     = 3'd5;
  localparam logic [2:0] KIND_DUMP_FWD   = 3'd6;
  localparam logic [2:0] KIND_DUMP_REV   = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NOPOS = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] position;
    logic [7:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] entry;
    logic       entry_valid;
    logic [4:0] count;
    logic       last;
  } res_t;

endpackage

// File: rtl/pbl_front.sv
// Front end: accepts items and holds them in a two-entry command queue.
module pbl_front
  import pbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_cmd
);

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       in_cmd;

  assign in_cmd.kind     = in_tdata[2:0];
  assign in_cmd.position = in_tdata[7:3];
  assign in_cmd.value    = in_tdata[15:8];

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = slot_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= in_cmd;
    end
  end

endmodule

// File: rtl/pbl_back.sv
// Back end: list storage, shift sequencer, dump reader and output register.
module pbl_back
  import pbl_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + 6;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_WR   = 3'd2;
  localparam logic [2:0] S_DN_RD   = 3'd3;
  localparam logic [2:0] S_DN_WR   = 3'd4;
  localparam logic [2:0] S_DUMP_RD = 3'd5;
  localparam logic [2:0] S_DUMP_EM = 3'd6;
  localparam logic [2:0] S_STAT    = 3'd7;

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rd_data_r;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [7:0]    wd;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [7:0]    val_r, val_nxt;
  logic          fwd_r, fwd_nxt;
  logic [1:0]    st_r, st_nxt;

  logic          out_valid_r;
  res_t          out_res_r;
  logic          want;
  res_t          want_res;
  logic          load;

  logic [XW-1:0] pos_x, occ_x;
  logic [CW-1:0] dump_addr;
  logic          dump_last;

  assign pos_x     = XW'(q_cmd.position);
  assign occ_x     = XW'(occ_r);
  assign dump_addr = fwd_r ? p_r : (occ_r - CW'(1) - p_r);
  assign dump_last = ((p_r + CW'(1)) == occ_r);
  assign q_ready   = (state_r == S_IDLE);
  assign load      = want && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    p_nxt     = p_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    fwd_nxt   = fwd_r;
    st_nxt    = st_r;
    we        = 1'b0;
    wa        = p_r[AW-1:0];
    wd        = rd_data_r;
    ra        = dump_addr[AW-1:0];
    want      = 1'b0;
    want_res.status      = st_r;
    want_res.entry       = 8'd0;
    want_res.entry_valid = 1'b0;
    want_res.count       = 5'(occ_r);
    want_res.last        = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          val_nxt = q_cmd.value;
          st_nxt  = ST_OK;
          p_nxt   = occ_r;
          unique case (q_cmd.kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              idx_nxt = (q_cmd.kind == KIND_PUSH_FRONT) ? CW'(0) : occ_r;
              if (occ_x >= XW'(CAPACITY)) begin
                st_nxt    = ST_FULL;
                state_nxt = S_STAT;
              end else begin
                state_nxt = S_UP_RD;
              end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
              p_nxt = (q_cmd.kind == KIND_POP_FRONT) ? CW'(0) : (occ_r - CW'(1));
              if (occ_r == CW'(0)) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_STAT;
              end else begin
                state_nxt = S_DN_RD;
              end
            end
            KIND_INSERT: begin
              idx_nxt = CW'(pos_x - XW'(1));
              if (pos_x < XW'(1) || pos_x > occ_x + XW'(1)) begin
                st_nxt    = ST_NOPOS;
                state_nxt = S_STAT;
              end else if (occ_x >= XW'(CAPACITY)) begin
                st_nxt    = ST_FULL;
                state_nxt = S_STAT;
              end else begin
                state_nxt = S_UP_RD;
              end
            end
            KIND_DELETE: begin
              p_nxt = CW'(pos_x - XW'(1));
              if (pos_x < XW'(1) || pos_x > occ_x) begin
                st_nxt    = ST_NOPOS;
                state_nxt = S_STAT;
              end else begin
                state_nxt = S_DN_RD;
              end
            end
            default: begin
              fwd_nxt = (q_cmd.kind == KIND_DUMP_FWD);
              p_nxt   = CW'(0);
              if (occ_r == CW'(0)) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_STAT;
              end else begin
                state_nxt = S_DUMP_RD;
              end
            end
          endcase
        end
      end
      S_UP_RD: begin
        ra = AW'(p_r - CW'(1));
        if (p_r == idx_r) begin
          we        = 1'b1;
          wd        = val_r;
          occ_nxt   = occ_r + CW'(1);
          state_nxt = S_STAT;
        end else begin
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        we        = 1'b1;
        p_nxt     = p_r - CW'(1);
        state_nxt = S_UP_RD;
      end
      S_DN_RD: begin
        ra = AW'(p_r + CW'(1));
        if ((p_r + CW'(1)) >= occ_r) begin
          occ_nxt   = occ_r - CW'(1);
          state_nxt = S_STAT;
        end else begin
          state_nxt = S_DN_WR;
        end
      end
      S_DN_WR: begin
        we        = 1'b1;
        p_nxt     = p_r + CW'(1);
        state_nxt = S_DN_RD;
      end
      S_DUMP_RD: begin
        state_nxt = S_DUMP_EM;
      end
      S_DUMP_EM: begin
        want                 = 1'b1;
        want_res.status      = ST_OK;
        want_res.entry       = rd_data_r;
        want_res.entry_valid = 1'b1;
        want_res.last        = dump_last;
        if (load) begin
          p_nxt     = p_r + CW'(1);
          state_nxt = dump_last ? S_IDLE : S_DUMP_RD;
        end
      end
      S_STAT: begin
        want = 1'b1;
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    fwd_r <= fwd_nxt;
    st_r  <= st_nxt;
    if (load) begin
      out_res_r <= want_res;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(occ_r) <= XW'(CAPACITY))
    else $error("occupancy above capacity");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == $past(occ_r)) || (occ_r == $past(occ_r) + CW'(1)) ||
    (occ_r == $past(occ_r) - CW'(1)))
    else $error("occupancy moved by more than one");

  a_occ_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> (occ_r == $past(occ_r)))
    else $error("occupancy changed while idle");

  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP_WR || state_r == S_DN_WR) |-> (p_r < CW'(CAPACITY)))
    else $error("shift pointer out of range");

endmodule

// File: rtl/positional_byte_list_top.sv
// Top level of the positional byte list: command queue and list engine.
//
// A bounded ordered list of bytes driven by a stream of commands. Each input
// item carries kind, position and value. Push, pop, insert and delete each
// give one status item with the new count. A dump gives one item per stored
// byte in forward or reverse order with tlast on the final one; a dump of an
// empty list gives one item with status empty and tlast set.
// Items enter a two-entry queue and are taken one at a time by the engine.
// An insert or delete moves the bytes behind its position one place along,
// each read from the list memory and then written back; pushes and pops at
// the ends that need no shift skip this. A dump reads each byte from the
// memory and then emits it as its own item.
// Results wait in an output register; while the receiver stalls, the engine
// holds and the queue fills, then in_tready falls.
// Reset empties the list and the queue; the byte storage is not cleared.
module positional_byte_list_top
  import pbl_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // kind[2:0], position[7:3], value[15:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[1:0], entry[9:2], entry_valid[10], count[15:11]
  output logic        out_tlast
);

  logic q_valid, q_ready;
  cmd_t q_cmd;
  res_t res;

  pbl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  pbl_back #(.CAPACITY(CAPACITY)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {res.count, res.entry_valid, res.entry, res.status};
  assign out_tlast = res.last;

endmodule

// File: dv/pbl_checker.sv
// Checker for the positional byte list: predicts results and compares them.
module pbl_checker
  import pbl_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] list_bytes [CAPACITY];
  int         list_len;
  res_t       expected_results [$];

  assign pending = expected_results.size();

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic res_t status_item(input logic [1:0] st);
    res_t r;
    r = '0;
    r.status = st;
    r.count = list_len[4:0];
    r.last = 1'b1;
    return r;
  endfunction

  task automatic add_at(input int idx, input logic [7:0] b);
    for (int i = list_len; i > idx; i--) list_bytes[i] = list_bytes[i-1];
    list_bytes[idx] = b;
    list_len++;
  endtask

  task automatic drop_at(input int idx);
    for (int i = idx; i + 1 < list_len; i++) list_bytes[i] = list_bytes[i+1];
    list_len--;
  endtask

  task automatic predict_list_op(input cmd_t c);
    res_t r;
    logic [1:0] st;
    int pos;
    st = ST_OK;
    pos = c.position;
    case (c.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (list_len >= CAPACITY) st = ST_FULL;
        else add_at(c.kind == KIND_PUSH_FRONT ? 0 : list_len, c.value);
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (list_len == 0) st = ST_EMPTY;
        else drop_at(c.kind == KIND_POP_FRONT ? 0 : list_len - 1);
      end
      KIND_INSERT: begin
        if (pos < 1 || pos > list_len + 1) st = ST_NOPOS;
        else if (list_len >= CAPACITY) st = ST_FULL;
        else add_at(pos - 1, c.value);
      end
      KIND_DELETE: begin
        if (pos < 1 || pos > list_len) st = ST_NOPOS;
        else drop_at(pos - 1);
      end
      default: begin
        if (list_len == 0) begin
          expected_results.push_back(status_item(ST_EMPTY));
        end else begin
          for (int i = 0; i < list_len; i++) begin
            r = '0;
            r.entry = list_bytes[c.kind == KIND_DUMP_FWD ? i : list_len - 1 - i];
            r.entry_valid = 1'b1;
            r.count = list_len[4:0];
            r.last = (i + 1 == list_len);
            expected_results.push_back(r);
          end
        end
        return;
      end
    endcase
    expected_results.push_back(status_item(st));
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      list_len = 0;
      errors = 0;
      results_seen = 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report("unexpected item", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[1:0] != want.status) report("status", out_tdata[1:0], want.status);
          if (out_tdata[9:2] != want.entry) report("entry", out_tdata[9:2], want.entry);
          if (out_tdata[10] != want.entry_valid)
            report("entry_valid", out_tdata[10], want.entry_valid);
          if (out_tdata[15:11] != want.count) report("count", out_tdata[15:11], want.count);
          if (out_tlast != want.last) report("last", out_tlast, want.last);
        end
      end
      if (in_tvalid && in_tready)
        predict_list_op(cmd_t'({in_tdata[2:0], in_tdata[7:3], in_tdata[15:8]}));
    end
  end
endmodule

// File: dv/testbench.sv
// Top of the positional byte list testbench: clock, reset, stimulus and verdict.
module testbench;
  import pbl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  int          errors;
  int          pending;
  int          results_seen;
  int          items_sent;
  int          fill_level;

  positional_byte_list_top i_dut (.*);

  pbl_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tlast, .errors, .pending, .results_seen
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic send_item(input logic [2:0] kind, input logic [4:0] pos,
                           input logic [7:0] val);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {val, pos, kind};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: if (fill_level < 16) fill_level++;
      KIND_POP_FRONT, KIND_POP_BACK: if (fill_level > 0) fill_level--;
      KIND_INSERT: if (pos >= 1 && pos <= fill_level + 1 && fill_level < 16) fill_level++;
      KIND_DELETE: if (pos >= 1 && pos <= fill_level) fill_level--;
      default: ;
    endcase
  endtask

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 19)) @(negedge clk);
        out_tready <= 1'b1;
        @(negedge clk);
        while (!(out_tvalid && out_tready)) @(negedge clk);
      end
    end
  end

  initial begin
    int k;
    int p;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    items_sent = 0;
    fill_level = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(KIND_POP_FRONT, 5'd0, 8'h00);
    send_item(KIND_POP_BACK, 5'd31, 8'hff);
    send_item(KIND_DELETE, 5'd1, 8'h00);
    send_item(KIND_DUMP_FWD, 5'd0, 8'h00);
    send_item(KIND_DUMP_REV, 5'd0, 8'h00);
    send_item(KIND_INSERT, 5'd0, 8'h11);
    send_item(KIND_INSERT, 5'd2, 8'h22);
    send_item(KIND_INSERT, 5'd1, 8'hff);
    send_item(KIND_PUSH_FRONT, 5'd31, 8'h00);
    send_item(KIND_PUSH_BACK, 5'd0, 8'h5a);
    send_item(KIND_INSERT, 5'd4, 8'ha5);
    send_item(KIND_INSERT, 5'd2, 8'h3c);
    for (int i = 0; i < 12; i++) send_item(KIND_PUSH_BACK, 5'd0, 8'(i * 17));
    send_item(KIND_PUSH_FRONT, 5'd0, 8'h77);
    send_item(KIND_INSERT, 5'd31, 8'h77);
    send_item(KIND_INSERT, 5'd3, 8'h77);
    send_item(KIND_DUMP_FWD, 5'd0, 8'h00);
    send_item(KIND_DUMP_REV, 5'd0, 8'h00);
    send_item(KIND_DELETE, 5'd16, 8'h00);
    send_item(KIND_DELETE, 5'd0, 8'h00);
    send_item(KIND_DELETE, 5'd1, 8'h00);

    while (items_sent < 250) begin
      k = $urandom_range(0, 99);
      if (k < 25) begin
        send_item(3'($urandom_range(0, 1)), 5'($urandom), 8'($urandom));
      end else if (k < 45) begin
        send_item(3'($urandom_range(2, 3)), 5'($urandom), 8'($urandom));
      end else if (k < 60) begin
        p = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                        : $urandom_range(1, fill_level + 1);
        send_item(KIND_INSERT, 5'(p), 8'($urandom));
      end else if (k < 75) begin
        p = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                        : $urandom_range(1, fill_level > 0 ? fill_level : 1);
        send_item(KIND_DELETE, 5'(p), 8'($urandom));
      end else begin
        send_item(3'($urandom_range(6, 7)), 5'($urandom), 8'($urandom));
      end
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d list operations and checked %0d result items,", items_sent,
             results_seen);
    $display("covering every operation, empty and full lists, and bad positions.");
    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/pbl_pkg.sv
rtl/pbl_front.sv
rtl/pbl_back.sv
rtl/positional_byte_list_top.sv
dv/pbl_checker.sv
dv/testbench.sv
